// ----- hw/rtl/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, register codes and controller states of the LFU cache
// engine.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Default number of entry slots.
    localparam int ENTRIES_DEF = 64;

    // Field widths.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0]   CAP_RESET    = 7'd64;

    // Operation codes carried by the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Fixed values.
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] CNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] CNT_INIT   = 32'd1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

endpackage

// ----- hw/rtl/lfu_cfg.sv -----
// ----------------------------------------------------------------------------
// lfu_cfg
// APB-style configuration register block holding the capacity register.
// ----------------------------------------------------------------------------
module lfu_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [lfu_pkg::CAP_W-1:0]   capacity
);

    logic [lfu_pkg::CAP_W-1:0]   capacity_reg;
    logic [lfu_pkg::CAP_W-1:0]   capacity_next;
    logic [lfu_pkg::PADDR_W-3:0] reg_index;
    logic                        wr_strobe;

    // Word address of the register selected on the bus.
    assign reg_index = paddr[lfu_pkg::PADDR_W-1:2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    // A write to an address beyond the register list is dropped.
    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_strobe && (reg_index == lfu_pkg::REG_CAPACITY))
        begin
            capacity_next = pwdata[lfu_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lfu_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb
    begin
        prdata = '0;
        if (reg_index == lfu_pkg::REG_CAPACITY)
        begin
            prdata = {{(32 - lfu_pkg::CAP_W){1'b0}}, capacity_reg};
        end
    end

    assign capacity = capacity_reg;

endmodule

// ----- hw/rtl/lfu_cache_engine.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_engine
// Key-value cache with least-frequently-used replacement, recency tie-break.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; its result appears
// on hit, read_value and evicted for the single cycle in which done is high,
// and must be taken then, since the block cannot be stalled. Each operation
// walks the entry memory once to find the key, the victim, a free slot and
// the fill level, one entry per cycle through its single read port. A get
// miss, or a put while the capacity is zero, ends there, and done is
// registered from the decision state. Every hit and every insert walks
// the memory a second time to rewrite recency ranks and the touched entry,
// and done is registered from the end of that second walk. busy drops in
// the cycle that carries done, so the next word may be accepted in that
// same cycle. Valid bits clear at reset; no clearing pass.
module lfu_cache_engine
#(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Command channel.
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic signed [31:0]          key,
    input  logic signed [31:0]          value,
    // Result channel.
    output logic                        done,
    output logic                        hit,
    output logic signed [31:0]          read_value,
    output logic                        evicted,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int DW   = lfu_pkg::DATA_W;
    localparam int RECW = 3 * DW + IW;

    // ------------------------------------------------------------------
    // Configuration and effective capacity.
    // ------------------------------------------------------------------
    logic [lfu_pkg::CAP_W-1:0] capacity;
    logic [31:0]               cap32;
    logic [CW-1:0]             cap_eff;

    lfu_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // A capacity above the slot count acts as the slot count.
    assign cap32   = {{(32 - lfu_pkg::CAP_W){1'b0}}, capacity};
    assign cap_eff = (cap32 > 32'(ENTRIES)) ? CW'(ENTRIES) : cap32[CW-1:0];

    // ------------------------------------------------------------------
    // Entry memory: {key, data, use count, recency rank} per slot.
    // ------------------------------------------------------------------
    logic [RECW-1:0] mem [ENTRIES];
    logic [RECW-1:0] rd_data_reg;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [RECW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Fields of the word just read.
    logic [DW-1:0] e_key;
    logic [DW-1:0] e_data;
    logic [DW-1:0] e_cnt;
    logic [IW-1:0] e_rank;

    assign e_key  = rd_data_reg[RECW-1 -: DW];
    assign e_data = rd_data_reg[RECW-DW-1 -: DW];
    assign e_cnt  = rd_data_reg[RECW-2*DW-1 -: DW];
    assign e_rank = rd_data_reg[IW-1:0];

    // ------------------------------------------------------------------
    // Control and datapath registers.
    // ------------------------------------------------------------------
    lfu_pkg::state_t state_reg, state_next;

    logic [CW-1:0]      addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      pend_idx_reg, pend_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic               mode_reg, mode_next;
    logic [DW-1:0]      key_reg, key_next;
    logic [DW-1:0]      value_reg, value_next;

    logic [CW-1:0]      held_reg, held_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    logic [DW-1:0]      hit_data_reg, hit_data_next;
    logic [DW-1:0]      hit_cnt_reg, hit_cnt_next;
    logic [IW-1:0]      hit_rank_reg, hit_rank_next;
    logic               vic_found_reg, vic_found_next;
    logic [IW-1:0]      vic_idx_reg, vic_idx_next;
    logic [DW-1:0]      vic_cnt_reg, vic_cnt_next;
    logic [IW-1:0]      vic_rank_reg, vic_rank_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;

    logic [IW-1:0]      tgt_idx_reg, tgt_idx_next;
    logic [RECW-1:0]    new_rec_reg, new_rec_next;
    logic               drop_en_reg, drop_en_next;
    logic [IW-1:0]      drop_rank_reg, drop_rank_next;

    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    logic [DW-1:0]      read_value_reg, read_value_next;
    logic               evicted_reg, evicted_next;

    // Decision helpers.
    logic               issue;
    logic               walk_end;
    logic               pend_valid;
    logic               evict_now;
    logic [IW-1:0]      ins_idx;
    logic [CW-1:0]      held_post;
    logic [DW-1:0]      cnt_inc;

    assign issue      = addr_reg < CW'(ENTRIES);
    assign walk_end   = (addr_reg == CW'(ENTRIES)) && pend_reg;
    assign pend_valid = valid_reg[pend_idx_reg];
    assign rd_addr    = addr_reg[IW-1:0];

    // Saturating use-count increment of the matched entry.
    assign cnt_inc = (hit_cnt_reg == lfu_pkg::CNT_MAX) ? hit_cnt_reg
                                                       : hit_cnt_reg + 1'b1;

    // Eviction and choice of the slot that receives a new key.
    assign evict_now = (held_reg >= cap_eff) && vic_found_reg;
    assign held_post = evict_now ? held_reg - 1'b1 : held_reg;
    always_comb
    begin
        ins_idx = free_idx_reg;
        if (evict_now && (!free_found_reg || (vic_idx_reg < free_idx_reg)))
        begin
            ins_idx = vic_idx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Next state, memory access and result.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        valid_next      = valid_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        held_next       = held_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        hit_cnt_next    = hit_cnt_reg;
        hit_rank_next   = hit_rank_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        new_rec_next    = new_rec_reg;
        drop_en_next    = drop_en_reg;
        drop_rank_next  = drop_rank_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        read_value_next = read_value_reg;
        evicted_next    = evicted_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = rd_data_reg;

        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                // Take the word and clear the walk accumulators.
                if (start)
                begin
                    mode_next       = mode;
                    key_next        = key;
                    value_next      = value;
                    held_next       = '0;
                    found_next      = 1'b0;
                    vic_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    addr_next       = '0;
                    pend_next       = 1'b0;
                    state_next      = lfu_pkg::ST_SCAN;
                end
            end

            lfu_pkg::ST_SCAN:
            begin
                // Read one slot per cycle; evaluate the previous one.
                rd_en         = issue;
                pend_next     = issue;
                pend_idx_next = addr_reg[IW-1:0];
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (pend_valid)
                    begin
                        held_next = held_reg + 1'b1;
                        if (e_key == key_reg)
                        begin
                            found_next    = 1'b1;
                            hit_idx_next  = pend_idx_reg;
                            hit_data_next = e_data;
                            hit_cnt_next  = e_cnt;
                            hit_rank_next = e_rank;
                        end
                        // Lowest count wins, then the least recent.
                        if (!vic_found_reg || (e_cnt < vic_cnt_reg) ||
                            ((e_cnt == vic_cnt_reg) && (e_rank < vic_rank_reg)))
                        begin
                            vic_found_next = 1'b1;
                            vic_idx_next   = pend_idx_reg;
                            vic_cnt_next   = e_cnt;
                            vic_rank_next  = e_rank;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                end
                if (walk_end)
                begin
                    state_next = lfu_pkg::ST_DECIDE;
                end
            end

            lfu_pkg::ST_DECIDE:
            begin
                hit_next        = found_reg;
                read_value_next = '0;
                evicted_next    = 1'b0;
                addr_next       = '0;
                pend_next       = 1'b0;
                state_next      = lfu_pkg::ST_IDLE;
                done_next       = 1'b1;
                if (mode_reg == lfu_pkg::MODE_GET)
                begin
                    if (found_reg)
                    begin
                        // Get hit: return data, touch the entry.
                        read_value_next = hit_data_reg;
                        tgt_idx_next    = hit_idx_reg;
                        new_rec_next    = {key_reg, hit_data_reg, cnt_inc,
                                           IW'(held_reg - 1'b1)};
                        drop_en_next    = 1'b1;
                        drop_rank_next  = hit_rank_reg;
                        state_next      = lfu_pkg::ST_UPDATE;
                        done_next       = 1'b0;
                    end
                    else
                    begin
                        read_value_next = lfu_pkg::MISS_VALUE;
                    end
                end
                else if (cap_eff != '0)
                begin
                    if (found_reg)
                    begin
                        // Put hit: new data, touch the entry.
                        tgt_idx_next   = hit_idx_reg;
                        new_rec_next   = {key_reg, value_reg, cnt_inc,
                                          IW'(held_reg - 1'b1)};
                        drop_en_next   = 1'b1;
                        drop_rank_next = hit_rank_reg;
                        state_next     = lfu_pkg::ST_UPDATE;
                        done_next      = 1'b0;
                    end
                    else if (free_found_reg || evict_now)
                    begin
                        // Put miss: drop the victim if full, then insert.
                        evicted_next   = evict_now;
                        drop_en_next   = evict_now;
                        drop_rank_next = vic_rank_reg;
                        if (evict_now)
                        begin
                            valid_next[vic_idx_reg] = 1'b0;
                        end
                        valid_next[ins_idx] = 1'b1;
                        tgt_idx_next   = ins_idx;
                        new_rec_next   = {key_reg, value_reg, lfu_pkg::CNT_INIT,
                                          IW'(held_post)};
                        state_next     = lfu_pkg::ST_UPDATE;
                        done_next      = 1'b0;
                    end
                end
            end

            lfu_pkg::ST_UPDATE:
            begin
                // Second walk: rewrite the target and close the rank gap.
                rd_en         = issue;
                pend_next     = issue;
                pend_idx_next = addr_reg[IW-1:0];
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (pend_idx_reg == tgt_idx_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = new_rec_reg;
                    end
                    else if (pend_valid && drop_en_reg && (e_rank > drop_rank_reg))
                    begin
                        wr_en   = 1'b1;
                        wr_data = {rd_data_reg[RECW-1:IW], e_rank - 1'b1};
                    end
                end
                if (walk_end)
                begin
                    done_next  = 1'b1;
                    state_next = lfu_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Payload and accumulator registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        held_reg       <= held_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_data_reg   <= hit_data_next;
        hit_cnt_reg    <= hit_cnt_next;
        hit_rank_reg   <= hit_rank_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        tgt_idx_reg    <= tgt_idx_next;
        new_rec_reg    <= new_rec_next;
        drop_en_reg    <= drop_en_next;
        drop_rank_reg  <= drop_rank_next;
        hit_reg        <= hit_next;
        read_value_reg <= read_value_next;
        evicted_reg    <= evicted_next;
    end

    // Ports.
    assign busy       = (state_reg != lfu_pkg::ST_IDLE);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The result word goes out as the engine returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the engine is busy");

    // An accepted word always starts a memory walk.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && (addr_reg == '0)))
        else $error("accepted word did not start a walk");

    // A get never evicts.
    a_get_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mode_reg == lfu_pkg::MODE_GET)) |-> !evicted)
        else $error("eviction reported on a get");

    // The fill level only moves on an insert, by at most one entry.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lfu_pkg::ST_DECIDE) |=>
            ($countones(valid_reg) == $countones($past(valid_reg))))
        else $error("valid bits changed outside the decision cycle");

endmodule
